// ===== sv/integer_upscale_scanout_defines.svh =====
// ----------------------------------------------------------------------------
// integer_upscale_scanout_defines.svh
// assertion macros used by the scanout upscaler controller
// ----------------------------------------------------------------------------
`ifndef INTEGER_UPSCALE_SCANOUT_DEFINES_SVH
`define INTEGER_UPSCALE_SCANOUT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, disabled while in reset
`define IUSC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("iusc: same-cycle check failed");
// next-cycle implication, disabled while in reset
`define IUSC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("iusc: next-cycle check failed");
`else
`define IUSC_ASSERT_IMP(lbl, ante, cons)
`define IUSC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== sv/iusc_pkg.sv =====
// ----------------------------------------------------------------------------
// iusc_pkg
// shared constants, register codes and control structs of the upscaler
// ----------------------------------------------------------------------------
package iusc_pkg;

    // previous-frame store
    localparam int MAX_LOGICAL_PIXELS = 65536;
    localparam int ADDR_W             = $clog2(MAX_LOGICAL_PIXELS);
    localparam int PIXEL_BITS         = 32;

    // replication
    localparam int MAX_SCALE = 8;
    localparam int SCALE_W   = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;

    // field widths
    localparam int ROW_W    = 12;
    localparam int COL_W    = 12;
    localparam int INDEX_W  = 24;
    localparam int LCOL_W   = 13;
    localparam int SCL_W    = 4;
    localparam int OFF_W    = 12;
    localparam int DCOL_W   = 13;
    localparam int CFG_A_W  = 3;
    localparam int CFG_D_W  = 13;
    localparam int IN_W     = 56;
    localparam int OUT_W    = 56;
    localparam int LADDR_W  = ROW_W + LCOL_W;
    localparam int DEV_W    = OFF_W + SCL_W + 1;

    // register indexes
    typedef enum logic [CFG_A_W-1:0] {
        CFG_LOGICAL_COLUMNS = 3'd0,
        CFG_SCALE           = 3'd1,
        CFG_OFFSET_X        = 3'd2,
        CFG_OFFSET_Y        = 3'd3,
        CFG_DEVICE_COLUMNS  = 3'd4
    } t_cfg_idx;

    // controller to datapath
    typedef struct packed {
        logic clear;
        logic load;
        logic mul;
        logic read;
        logic start;
        logic advance;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
        logic in_range;
        logic differ;
        logic last;
    } t_dp_sts;

endpackage

// ===== sv/integer_upscale_scanout.sv =====
// ----------------------------------------------------------------------------
// integer_upscale_scanout
// nearest-neighbor integer upscaler with per-pixel change detection
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  s         in         i_s_tvalid/o_s_tready  row, column, pixel_value
//  m         out        o_m_tvalid/i_m_tready  device_pixel_index, out_pixel, tlast
//  cfg       in         i_cfg_wr_en            i_cfg_addr, i_cfg_wdata
//
//  an ignored item passes S_IDLE, S_MUL and S_READ; an unchanged one also S_CMP
//  a changed item emits scale*scale outputs in S_EMIT, one per cycle while i_m_tready
//  after reset a clearing pass fills all 65536 store entries with ones, no item taken
//  one item at a time; a stalled output holds its item until i_m_tready
// ----------------------------------------------------------------------------
module integer_upscale_scanout (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [iusc_pkg::CFG_A_W-1:0]  i_cfg_addr,
    input  logic [iusc_pkg::CFG_D_W-1:0]  i_cfg_wdata,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // row, column, pixel_value from the lowest bit up
    input  logic [iusc_pkg::IN_W-1:0]     i_s_tdata,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // device_pixel_index, out_pixel from the lowest bit up
    output logic [iusc_pkg::OUT_W-1:0]    o_m_tdata,
    output logic                          o_m_tlast
);
    import iusc_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencing
    iusc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // arithmetic and store
    iusc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tdata   (i_s_tdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

endmodule

// ===== sv/iusc_ram.sv =====
// ----------------------------------------------------------------------------
// iusc_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module iusc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/iusc_dp.sv =====
// ----------------------------------------------------------------------------
// iusc_dp
// datapath: config registers, address and index arithmetic, frame store
// ----------------------------------------------------------------------------
module iusc_dp (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [iusc_pkg::CFG_A_W-1:0] i_cfg_addr,
    input  logic [iusc_pkg::CFG_D_W-1:0] i_cfg_wdata,
    // row, column, pixel_value from the lowest bit up
    input  logic [iusc_pkg::IN_W-1:0] i_s_tdata,
    input  iusc_pkg::t_dp_cmd        i_cmd,
    output iusc_pkg::t_dp_sts        o_sts,
    // device_pixel_index, out_pixel from the lowest bit up
    output logic [iusc_pkg::OUT_W-1:0] o_m_tdata,
    output logic                     o_m_tlast
);
    import iusc_pkg::*;

    // config registers
    logic [LCOL_W-1:0] r_lc;
    logic [SCL_W-1:0]  r_scale;
    logic [OFF_W-1:0]  r_ox;
    logic [OFF_W-1:0]  r_oy;
    logic [DCOL_W-1:0] r_dc;

    // item registers
    logic [ROW_W-1:0]      r_row;
    logic [COL_W-1:0]      r_col;
    logic [PIXEL_BITS-1:0] r_pix;
    logic [LADDR_W-1:0]    r_addr;
    logic                  r_col_ok;
    logic [DEV_W-1:0]      r_dy0;
    logic [DEV_W-1:0]      r_dx0;
    logic [INDEX_W-1:0]    r_base;
    logic [INDEX_W-1:0]    r_idx;
    logic [INDEX_W-1:0]    r_row_idx;
    logic [SCALE_W-1:0]    r_r;
    logic [SCALE_W-1:0]    r_c;
    logic [ADDR_W-1:0]     r_clr;

    logic [SCL_W-1:0]      s_eff;
    logic [SCALE_W-1:0]    s_m1;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [PIXEL_BITS-1:0] wr_data;
    logic [PIXEL_BITS-1:0] rd_data;

    // config writes, indexes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lc    <= LCOL_W'(64);
            r_scale <= SCL_W'(1);
            r_ox    <= '0;
            r_oy    <= '0;
            r_dc    <= DCOL_W'(3840);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_LOGICAL_COLUMNS: r_lc    <= i_cfg_wdata[LCOL_W-1:0];
                CFG_SCALE:           r_scale <= i_cfg_wdata[SCL_W-1:0];
                CFG_OFFSET_X:        r_ox    <= i_cfg_wdata[OFF_W-1:0];
                CFG_OFFSET_Y:        r_oy    <= i_cfg_wdata[OFF_W-1:0];
                CFG_DEVICE_COLUMNS:  r_dc    <= i_cfg_wdata[DCOL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // effective scale, zero reads as one, saturates at the maximum
    always_comb begin
        if (r_scale == '0) begin
            s_eff = SCL_W'(1);
        end else if (r_scale > SCL_W'(MAX_SCALE)) begin
            s_eff = SCL_W'(MAX_SCALE);
        end else begin
            s_eff = r_scale;
        end
        s_m1 = SCALE_W'(s_eff - SCL_W'(1));
    end

    // clearing pass counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clear) begin
            r_clr <= r_clr + ADDR_W'(1);
        end
    end

    // item capture and arithmetic
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_row <= i_s_tdata[ROW_W-1:0];
            r_col <= i_s_tdata[ROW_W+COL_W-1:ROW_W];
            r_pix <= i_s_tdata[ROW_W+COL_W+PIXEL_BITS-1:ROW_W+COL_W];
        end
        // logical address and block origin
        if (i_cmd.mul) begin
            r_addr   <= LADDR_W'(r_row) * LADDR_W'(r_lc) + LADDR_W'(r_col);
            r_col_ok <= LCOL_W'(r_col) < r_lc;
            r_dy0    <= DEV_W'(r_oy) + DEV_W'(r_row) * DEV_W'(s_eff);
            r_dx0    <= DEV_W'(r_ox) + DEV_W'(r_col) * DEV_W'(s_eff);
        end
        // device index of the block origin, wraps at the index width
        if (i_cmd.read) begin
            r_base <= INDEX_W'(r_dy0) * INDEX_W'(r_dc) + INDEX_W'(r_dx0);
        end
        if (i_cmd.start) begin
            r_r       <= '0;
            r_c       <= '0;
            r_idx     <= r_base;
            r_row_idx <= r_base;
        end
        // walk the block row by row
        if (i_cmd.advance) begin
            if (r_c == s_m1) begin
                r_c       <= '0;
                r_r       <= r_r + SCALE_W'(1);
                r_row_idx <= r_row_idx + INDEX_W'(r_dc);
                r_idx     <= r_row_idx + INDEX_W'(r_dc);
            end else begin
                r_c   <= r_c + SCALE_W'(1);
                r_idx <= r_idx + INDEX_W'(1);
            end
        end
    end

    // store write: clearing pass or update of a changed pixel
    always_comb begin
        if (i_cmd.clear) begin
            wr_en   = 1'b1;
            wr_addr = r_clr;
            wr_data = '1;
        end else begin
            wr_en   = i_cmd.start && (rd_data != r_pix);
            wr_addr = r_addr[ADDR_W-1:0];
            wr_data = r_pix;
        end
    end

    iusc_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_LOGICAL_PIXELS)
    ) u_prev_frame (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (i_cmd.read),
        .i_rd_addr (r_addr[ADDR_W-1:0]),
        .o_rd_data (rd_data)
    );

    // status back to the controller
    assign o_sts.clear_done = (r_clr == ADDR_W'(MAX_LOGICAL_PIXELS - 1));
    assign o_sts.in_range   = r_col_ok && (r_addr < LADDR_W'(MAX_LOGICAL_PIXELS));
    assign o_sts.differ     = (rd_data != r_pix);
    assign o_sts.last       = (r_r == s_m1) && (r_c == s_m1);

    // result item
    assign o_m_tdata = {r_pix, r_idx};
    assign o_m_tlast = (r_r == s_m1) && (r_c == s_m1);

endmodule

// ===== sv/iusc_ctrl.sv =====
// ----------------------------------------------------------------------------
// iusc_ctrl
// controller: clearing pass, per-item sequencing and write emission
// ----------------------------------------------------------------------------
`include "integer_upscale_scanout_defines.svh"

module iusc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    input  iusc_pkg::t_dp_sts i_sts,
    output iusc_pkg::t_dp_cmd o_cmd
);
    import iusc_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_MUL   = 6'b000100,
        S_READ  = 6'b001000,
        S_CMP   = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_cmd.load = i_s_tvalid;
                if (i_s_tvalid) n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_READ;
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = i_sts.in_range ? S_CMP : S_IDLE;
            end
            S_CMP: begin
                o_cmd.start = 1'b1;
                n_state     = i_sts.differ ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                o_cmd.advance = i_m_tready;
                if (i_m_tready && i_sts.last) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = (r_state == S_EMIT);

    // checks
    `IUSC_ASSERT_NXT(a_block_ends, (r_state == S_EMIT) && i_m_tready && i_sts.last, r_state == S_IDLE)
    `IUSC_ASSERT_NXT(a_clear_once, r_state != S_CLEAR, r_state != S_CLEAR)
    `IUSC_ASSERT_NXT(a_same_skips, (r_state == S_CMP) && !i_sts.differ, r_state == S_IDLE)
    `IUSC_ASSERT_IMP(a_no_overlap, o_m_tvalid, !o_s_tready && !o_cmd.load)

endmodule
